FILE: rtl/core/fsc_pkg.sv
// fsc_pkg: types and constants shared by the FEC strength controller.
// No dependencies.
package fsc_pkg;

  localparam int LOSS_W   = 10;
  localparam int TIME_W   = 48;
  localparam int CODE_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int LEVEL_W  = 2;
  localparam int ANOM_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int LEVEL_CODES = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_CODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3_CODE    = 3'd5;

  localparam logic [LOSS_W-1:0] THRESHOLD_RESET = 10'd10;
  localparam logic [TIME_W-1:0] HOLD_RESET      = 48'd10000000;

  localparam logic               ACT_REPORT = 1'b0;
  localparam logic               ACT_QUERY  = 1'b1;

  localparam logic [ANOM_W-1:0] ANOM_NONE         = 2'd0;
  localparam logic [ANOM_W-1:0] ANOM_SESSION_HIGH = 2'd1;
  localparam logic [ANOM_W-1:0] ANOM_FEC_CLOSED   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DEADLINE,
    ST_DECIDE
  } state_t;

endpackage

FILE: rtl/core/fec_strength_controller_unit.sv
// fec_strength_controller_unit: loss window, serial averaging divider and
// FEC level decision. Depends on fsc_pkg.
//
//   channel | direction | transfer carries
//   --------+-----------+--------------------------------------------------
//   cfg_    | in        | cfg_index, cfg_data (register write)
//   in_     | in        | in_action, in_residual_loss, in_session_loss, in_now_time
//   out_    | out       | out_level, out_fec_k, out_fec_r, out_anomaly
//
// Report: after the input transfer, the window is read and updated, then the
// restoring divider (SumW-bit sums, SumW = 10 + clog2(WINDOW_DEPTH+1), 15 at
// depth 16) computes both averages, which share it, one quotient bit per cycle.
// Query: deadline add, then compare and decide, which waits for the output
// register to drain. in_ready is high only in idle.
// Synchronous active-low reset; old entries are subtracted once the window is full.
module fec_strength_controller_unit #(
  parameter int WINDOW_DEPTH = 16,
  parameter int LEVEL_COUNT  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsc_pkg::TIME_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [fsc_pkg::LOSS_W-1:0]     in_residual_loss,
  input  logic [fsc_pkg::LOSS_W-1:0]     in_session_loss,
  input  logic [fsc_pkg::TIME_W-1:0]     in_now_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fsc_pkg::LEVEL_W-1:0]    out_level,
  output logic [fsc_pkg::BYTE_W-1:0]     out_fec_k,
  output logic [fsc_pkg::BYTE_W-1:0]     out_fec_r,
  output logic [fsc_pkg::ANOM_W-1:0]     out_anomaly
);
  import fsc_pkg::*;

  localparam int FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int HeadW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SumW  = LOSS_W + FillW;
  localparam int CntW  = $clog2(SumW + 1);
  localparam logic [FillW-1:0]   FillFull = FillW'(WINDOW_DEPTH);
  localparam logic [HeadW-1:0]   HeadLast = HeadW'(WINDOW_DEPTH - 1);
  localparam logic [CntW-1:0]    CntLast  = CntW'(SumW - 1);
  localparam logic [LEVEL_W-1:0] LevelTop = LEVEL_W'(LEVEL_COUNT - 1);

  // configuration
  logic [LOSS_W-1:0] threshold_r;
  logic [TIME_W-1:0] hold_r;
  logic [CODE_W-1:0] level_code_r [LEVEL_CODES];

  // window and statistics
  logic [LOSS_W-1:0] fec_mem [WINDOW_DEPTH];
  logic [LOSS_W-1:0] ses_mem [WINDOW_DEPTH];
  logic [LOSS_W-1:0] fec_old_r, ses_old_r;
  logic [HeadW-1:0]  head_r;
  logic [FillW-1:0]  fill_r;
  logic [SumW-1:0]   fec_sum_r, ses_sum_r;
  logic [LOSS_W-1:0] fec_avg_r, ses_avg_r;
  logic [LEVEL_W-1:0] level_r;
  logic [TIME_W-1:0]  last_change_r;

  // input latches
  logic [LOSS_W-1:0] fec_in_r, ses_in_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W:0]   deadline_r;

  // divider
  logic [SumW-1:0]  div_q_r;
  logic [FillW-1:0] div_rem_r;
  logic [CntW-1:0]  div_cnt_r;
  logic             div_sel_r;

  // output register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [BYTE_W-1:0]  out_k_r, out_r_r;
  logic [ANOM_W-1:0]  out_anom_r;

  state_t state_r, state_nxt;

  logic in_xfer, mem_we, div_step, decide_fire, out_free, div_last;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_action == ACT_QUERY) ? ST_DEADLINE : ST_READ;
        end
      end
      ST_READ:     state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_last && div_sel_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DEADLINE: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    div_step    = 1'b0;
    decide_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready    = 1'b1;
      ST_UPDATE: mem_we      = 1'b1;
      ST_DIVIDE: div_step    = 1'b1;
      ST_DECIDE: decide_fire = out_free;
      default: begin
      end
    endcase
  end

  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign div_last  = div_cnt_r == CntLast;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      hold_r      <= HOLD_RESET;
      for (int i = 0; i < LEVEL_CODES; i++) begin
        level_code_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOSS_THRESHOLD: threshold_r     <= cfg_data[LOSS_W-1:0];
        CFG_HOLD_TIME:      hold_r          <= cfg_data;
        CFG_LEVEL0_CODE:    level_code_r[0] <= cfg_data[CODE_W-1:0];
        CFG_LEVEL1_CODE:    level_code_r[1] <= cfg_data[CODE_W-1:0];
        CFG_LEVEL2_CODE:    level_code_r[2] <= cfg_data[CODE_W-1:0];
        CFG_LEVEL3_CODE:    level_code_r[3] <= cfg_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fec_mem[head_r] <= fec_in_r;
      ses_mem[head_r] <= ses_in_r;
    end
    fec_old_r <= fec_mem[head_r];
    ses_old_r <= ses_mem[head_r];
  end

  // sums, head, fill
  logic             full;
  logic [SumW-1:0]  fec_sum_nxt, ses_sum_nxt;
  logic [HeadW-1:0] head_nxt;

  always_comb begin
    full        = fill_r == FillFull;
    fec_sum_nxt = fec_sum_r - (full ? SumW'(fec_old_r) : '0) + SumW'(fec_in_r);
    ses_sum_nxt = ses_sum_r - (full ? SumW'(ses_old_r) : '0) + SumW'(ses_in_r);
    head_nxt    = (head_r == HeadLast) ? '0 : head_r + 1'b1;
  end

  // divider step
  logic [FillW:0]   rem_shift;
  logic             rem_ge;
  logic [FillW-1:0] rem_new;
  logic [SumW-1:0]  q_new;

  always_comb begin
    rem_shift = {div_rem_r, div_q_r[SumW-1]};
    rem_ge    = rem_shift >= {1'b0, fill_r};
    rem_new   = rem_ge ? FillW'(rem_shift - {1'b0, fill_r}) : rem_shift[FillW-1:0];
    q_new     = {div_q_r[SumW-2:0], rem_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      fec_sum_r <= '0;
      ses_sum_r <= '0;
      fec_avg_r <= '0;
      ses_avg_r <= '0;
      div_sel_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      if (mem_we) begin
        fec_sum_r <= fec_sum_nxt;
        ses_sum_r <= ses_sum_nxt;
        head_r    <= head_nxt;
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
        div_sel_r <= 1'b0;
        div_cnt_r <= '0;
      end else if (div_step) begin
        if (div_last) begin
          div_cnt_r <= '0;
          div_sel_r <= 1'b1;
          if (div_sel_r) begin
            ses_avg_r <= q_new[LOSS_W-1:0];
          end else begin
            fec_avg_r <= q_new[LOSS_W-1:0];
          end
        end else begin
          div_cnt_r <= div_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      div_q_r   <= fec_sum_nxt;
      div_rem_r <= '0;
    end else if (div_step) begin
      if (div_last && !div_sel_r) begin
        div_q_r   <= ses_sum_r;
        div_rem_r <= '0;
      end else begin
        div_q_r   <= q_new;
        div_rem_r <= rem_new;
      end
    end
  end

  // input latches and deadline
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fec_in_r <= in_residual_loss;
      ses_in_r <= in_session_loss;
      now_r    <= in_now_time;
    end
    if (state_r == ST_DEADLINE) begin
      deadline_r <= {1'b0, last_change_r} + {1'b0, hold_r};
    end
  end

  // decision
  logic               held, ses_high, changed;
  logic [LEVEL_W-1:0] level_nxt;
  logic [ANOM_W-1:0]  anom_nxt;
  logic [CODE_W-1:0]  code_sel;

  always_comb begin
    held      = deadline_r <= {1'b0, now_r};
    ses_high  = ses_avg_r > threshold_r;
    level_nxt = level_r;
    changed   = 1'b0;
    anom_nxt  = ANOM_NONE;
    priority if (fec_avg_r == '0) begin
      priority if (level_r == '0) begin
        if (ses_high) begin
          level_nxt = LEVEL_W'(1);
          changed   = 1'b1;
        end
      end else if (ses_avg_r != '0) begin
        if (ses_high) begin
          anom_nxt = ANOM_SESSION_HIGH;
        end
      end else if (held) begin
        level_nxt = '0;
        changed   = 1'b1;
      end else begin
      end
    end else begin
      priority if (level_r == '0) begin
        anom_nxt = ANOM_FEC_CLOSED;
      end else if (ses_high && held && level_r < LevelTop) begin
        level_nxt = level_r + 1'b1;
        changed   = 1'b1;
      end else begin
      end
    end
    code_sel = level_code_r[level_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= '0;
      last_change_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (decide_fire) begin
        level_r     <= level_nxt;
        out_valid_r <= 1'b1;
        if (changed) begin
          last_change_r <= now_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (decide_fire) begin
      out_level_r <= level_nxt;
      out_k_r     <= code_sel[CODE_W-1:BYTE_W];
      out_r_r     <= code_sel[BYTE_W-1:0];
      out_anom_r  <= anom_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_fec_k   = out_k_r;
  assign out_fec_r   = out_r_r;
  assign out_anomaly = out_anom_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillFull)
    else $error("window fill count above depth");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LevelTop)
    else $error("level above top level");

  a_level_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(level_r) |-> $past(state_r == ST_DECIDE))
    else $error("level changed outside decision step");

  a_avg_change: assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(fec_avg_r) || !$stable(ses_avg_r)) |-> $past(state_r == ST_DIVIDE))
    else $error("average changed outside divide");
`endif

endmodule
